@@ sv/ggm_pkg.sv @@
// shared types and constants of the gated gain mixer
package ggm_pkg;

  // number of mixed sources and field widths
  localparam int SOURCES  = 4;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 11;

  // register map: one 32-bit word per register
  localparam int REG_COUNT = SOURCES + 3;
  localparam int ADDR_W    = $clog2(4 * REG_COUNT);
  localparam int IDX_W     = ADDR_W - 2;
  localparam int SEL_W     = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  // register indexes past the gain registers
  localparam logic [IDX_W-1:0] REG_MUTE     = IDX_W'(SOURCES);
  localparam logic [IDX_W-1:0] REG_GATE_EN  = IDX_W'(SOURCES + 1);
  localparam logic [IDX_W-1:0] REG_GATE_THR = IDX_W'(SOURCES + 2);

  // q1.15 unity gain and int16 limits
  localparam logic [GAIN_W-1:0]          GAIN_UNITY = 16'h8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // configuration seen by the cells
  typedef struct packed {
    logic [SOURCES-1:0][GAIN_W-1:0] gain;
    logic [SOURCES-1:0]             mute;
    logic                           gate_en;
    logic [THR_W-1:0]               thr;
  } cfg_t;

  // one item on its way down the chain, with its running sum
  typedef struct packed {
    logic [SOURCES-1:0]               present;
    logic [SOURCES-1:0][SAMPLE_W-1:0] samples;
    logic [SAMPLE_W-1:0]              acc;
  } item_t;

endpackage

@@ sv/gated_gain_mixer.sv @@
// top level: four-source saturating mixer with noise gate and apb registers
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_source_sample_0..3, in_present_mask
//   out      output     out_valid/out_stall out_mixed_sample
//   cfg      input      psel/penable/pready paddr, pwdata, prdata
//
// one item per cycle sustained unless out_stall holds the chain; each item
// passes every cell in turn, each serving one source with a 16x17 multiplier.
// synchronous active-low reset empties the chain and sets gains to unity.
// out_stall holds the last cell; earlier cells keep moving into empty slots.
// in_stall rises only when every cell holds an item and out_stall is high.
module gated_gain_mixer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                in_source_sample_0,
  input  logic [15:0]                in_source_sample_1,
  input  logic [15:0]                in_source_sample_2,
  input  logic [15:0]                in_source_sample_3,
  input  logic [3:0]                 in_present_mask,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_mixed_sample,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ggm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ggm_pkg::*;

  cfg_t  cfg;
  logic  stage_valid [SOURCES+1];
  logic  stage_ready [SOURCES+1];
  item_t stage_item  [SOURCES+1];

  // register file
  ggm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );
  assign pready = 1'b1;

  // incoming item enters the chain with an empty sum
  assign stage_valid[0]         = in_valid;
  assign stage_item[0].present  = in_present_mask;
  assign stage_item[0].samples  = {in_source_sample_3, in_source_sample_2,
                                   in_source_sample_1, in_source_sample_0};
  assign stage_item[0].acc      = '0;
  assign in_stall               = !stage_ready[0];

  // chain of cells, cell i mixes source i
  for (genvar i = 0; i < SOURCES; i++) begin : g_cell
    ggm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stage_valid[i]),
      .up_ready (stage_ready[i]),
      .up_item  (stage_item[i]),
      .dn_valid (stage_valid[i+1]),
      .dn_ready (stage_ready[i+1]),
      .dn_item  (stage_item[i+1]),
      .sample   ($signed(stage_item[i].samples[i])),
      .present  (stage_item[i].present[i]),
      .gain     (cfg.gain[i]),
      .mute     (cfg.mute[i]),
      .gate_en  (cfg.gate_en),
      .thr      (cfg.thr)
    );
  end

  // last cell is the output register
  assign stage_ready[SOURCES] = !out_stall;
  assign out_valid            = stage_valid[SOURCES];
  assign out_mixed_sample     = stage_item[SOURCES].acc;

  // input is held back only by a full chain behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the chain");

  // reset empties the chain
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result left after reset");

  // an accepted item occupies the first cell
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> stage_valid[1])
    else $error("accepted item did not enter the chain");

endmodule

@@ sv/ggm_regs.sv @@
// apb register file holding gains, mute mask and noise gate settings
module ggm_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ggm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output ggm_pkg::cfg_t              cfg
);
  import ggm_pkg::*;

  logic [SOURCES-1:0][GAIN_W-1:0] gain_r;
  logic [SOURCES-1:0]             mute_r;
  logic                           gate_en_r;
  logic [THR_W-1:0]               thr_r;
  logic [IDX_W-1:0]               idx;
  logic                           wr_en;

  // word index and write strobe
  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SOURCES; i++) begin
        gain_r[i] <= GAIN_UNITY;
      end
      mute_r    <= '0;
      gate_en_r <= 1'b0;
      thr_r     <= '0;
    end else if (wr_en) begin
      priority if (idx < IDX_W'(SOURCES)) begin
        gain_r[idx[SEL_W-1:0]] <= pwdata[GAIN_W-1:0];
      end else if (idx == REG_MUTE) begin
        mute_r <= pwdata[SOURCES-1:0];
      end else if (idx == REG_GATE_EN) begin
        gate_en_r <= pwdata[0];
      end else if (idx == REG_GATE_THR) begin
        thr_r <= pwdata[THR_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    priority if (idx < IDX_W'(SOURCES)) begin
      prdata = {{(32-GAIN_W){1'b0}}, gain_r[idx[SEL_W-1:0]]};
    end else if (idx == REG_MUTE) begin
      prdata = {{(32-SOURCES){1'b0}}, mute_r};
    end else if (idx == REG_GATE_EN) begin
      prdata = {31'd0, gate_en_r};
    end else if (idx == REG_GATE_THR) begin
      prdata = {{(32-THR_W){1'b0}}, thr_r};
    end else begin
      prdata = '0;
    end
  end

  assign cfg.gain    = gain_r;
  assign cfg.mute    = mute_r;
  assign cfg.gate_en = gate_en_r;
  assign cfg.thr     = thr_r;

  // writes land in the addressed register
  a_mute_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && idx == REG_MUTE |=> mute_r == $past(pwdata[SOURCES-1:0]))
    else $error("mute mask write lost");

  a_gate_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && idx == REG_GATE_EN |=> gate_en_r == $past(pwdata[0]))
    else $error("gate enable write lost");

  a_thr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && idx == REG_GATE_THR) |=> $stable(thr_r))
    else $error("threshold changed without a write");

endmodule

@@ sv/ggm_cell.sv @@
// one mixer cell: gates and scales its source, adds it with saturation
module ggm_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  ggm_pkg::item_t                    up_item,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output ggm_pkg::item_t                    dn_item,
  input  logic signed [ggm_pkg::SAMPLE_W-1:0] sample,
  input  logic                              present,
  input  logic [ggm_pkg::GAIN_W-1:0]        gain,
  input  logic                              mute,
  input  logic                              gate_en,
  input  logic [ggm_pkg::THR_W-1:0]         thr
);
  import ggm_pkg::*;

  logic                       valid_r;
  item_t                      item_r;
  logic                       load;
  logic                       use_src;
  logic [SAMPLE_W:0]          mag;
  logic                       gated;
  logic signed [SAMPLE_W-1:0] s_g;
  logic [GAIN_W-1:0]          g_c;
  logic signed [GAIN_W:0]     g_s;
  logic signed [32:0]         prod;
  logic signed [32:0]         adj;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W:0]   sum;
  logic [SAMPLE_W-1:0]        acc_nxt;

  // handshake with the neighbors
  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign use_src  = present && !mute;

  // noise gate on the magnitude, -32768 counts as 32768
  assign mag   = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample})
                                    : {sample[SAMPLE_W-1], sample};
  assign gated = gate_en && (mag < {{(SAMPLE_W+1-THR_W){1'b0}}, thr});
  assign s_g   = gated ? '0 : sample;

  // gain clamped to unity, q1.15 product truncated toward zero
  assign g_c    = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;
  assign g_s    = $signed({1'b0, g_c});
  assign prod   = s_g * g_s;
  assign adj    = prod[32] ? (prod + 33'sd32767) : prod;
  assign scaled = adj[30:15];

  // saturating add into the running sum
  always_comb begin
    sum = {up_item.acc[SAMPLE_W-1], up_item.acc} + {scaled[SAMPLE_W-1], scaled};
    if (!use_src) begin
      acc_nxt = up_item.acc;
    end else if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      acc_nxt = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      acc_nxt = sum[SAMPLE_W-1:0];
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.present <= up_item.present;
      item_r.samples <= up_item.samples;
      item_r.acc     <= acc_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // a blocked item holds its place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dn_ready |=> valid_r && $stable(item_r))
    else $error("cell dropped or changed a blocked item");

  // a skipped source leaves the sum alone
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    load && !use_src |=> item_r.acc == $past(up_item.acc))
    else $error("skipped source changed the sum");

  // a gated sample adds nothing
  a_gate: assert property (@(posedge clk) disable iff (!rst_n)
    load && use_src && gated |=> item_r.acc == $past(up_item.acc))
    else $error("gated sample changed the sum");

endmodule

@@ sim/tb.sv @@
// self-checking testbench of the gated gain mixer: directed and random items against a mix predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ggm_pkg::*;

  // one input item: a sample per source and the present mask
  typedef struct packed {
    logic [SOURCES-1:0][SAMPLE_W-1:0] smp;
    logic [SOURCES-1:0]               present;
  } sample_set_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [SOURCES-1:0][SAMPLE_W-1:0] drv_samples = '0;
  logic [SOURCES-1:0]               drv_present = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [SAMPLE_W-1:0]              out_mixed_sample;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [ADDR_W-1:0]                paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  // register copies seen by the predictor
  logic [GAIN_W-1:0] gain_r [SOURCES];
  logic [SOURCES-1:0] mute_r = '0;
  logic               gate_en_r = 1'b0;
  logic [THR_W-1:0]   thr_r = '0;

  sample_set_t         sample_sets[$];
  logic [SAMPLE_W-1:0] expected_mix[$];
  sample_set_t         cur_set;
  int                  gap_left = 0;
  int                  stall_left = 0;
  bit                  in_idle = 0;
  bit                  out_idle = 0;
  int                  fail_count = 0;

  gated_gain_mixer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_sample_0 (drv_samples[0]),
    .in_source_sample_1 (drv_samples[1]),
    .in_source_sample_2 (drv_samples[2]),
    .in_source_sample_3 (drv_samples[3]),
    .in_present_mask    (drv_present),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mixed_sample   (out_mixed_sample),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  always #5 clk = ~clk;

  // gate, clamp gain, scale toward zero and add with saturation in source order
  function automatic logic [SAMPLE_W-1:0] mix_predict(sample_set_t set);
    int     acc;
    int     s;
    int     mag;
    longint g;
    longint p;
    longint scaled;
    acc = 0;
    for (int i = 0; i < SOURCES; i++) begin
      if (!set.present[i] || mute_r[i]) continue;
      s = $signed(set.smp[i]);
      mag = (s < 0) ? -s : s;
      if (gate_en_r && mag < int'(thr_r)) s = 0;
      g = (gain_r[i] > GAIN_UNITY) ? longint'(GAIN_UNITY) : longint'(gain_r[i]);
      p = longint'(s) * g;
      scaled = (p < 0) ? -((-p) >> 15) : (p >> 15);
      acc = acc + int'(scaled);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  // driver: one item per handshake, random gap after each item in idle phases
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_mix = {expected_mix, mix_predict(cur_set)};
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_sets.size() != 0) begin
          cur_set = sample_sets.pop_front();
          drv_samples <= cur_set.smp;
          drv_present <= cur_set.present;
          in_valid <= 1'b1;
          gap_left = in_idle ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expected mix, random stall after each in idle phases
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_mix.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: mixed_sample %0d", $signed(out_mixed_sample));
          fail_count++;
        end else if (out_mixed_sample !== expected_mix[0]) begin
          if (fail_count < 10)
            $display("mismatch: mixed_sample expected %0d got %0d",
                     $signed(expected_mix[0]), $signed(out_mixed_sample));
          fail_count++;
          void'(expected_mix.pop_front());
        end else begin
          void'(expected_mix.pop_front());
        end
        stall_left = out_idle ? $urandom_range(0, 3) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // apb write: setup then access, mirror into the predictor copy
  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < SOURCES) begin
      gain_r[idx] = val[GAIN_W-1:0];
    end else begin
      case (idx)
        int'(REG_MUTE):     mute_r = val[SOURCES-1:0];
        int'(REG_GATE_EN):  gate_en_r = val[0];
        int'(REG_GATE_THR): thr_r = val[THR_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
  endtask

  task automatic add_item(input int s0, input int s1, input int s2, input int s3,
                          input logic [3:0] mask);
    sample_set_t set;
    set.smp[0] = 16'(s0);
    set.smp[1] = 16'(s1);
    set.smp[2] = 16'(s2);
    set.smp[3] = 16'(s3);
    set.present = mask;
    sample_sets = {sample_sets, set};
  endtask

  // sender pauses here until every item is sent and every result is back
  task automatic wait_drained;
    do @(negedge clk);
    while (sample_sets.size() != 0 || in_valid || expected_mix.size() != 0);
  endtask

  // stimulus
  initial begin
    sample_set_t set;
    int          v;
    int          g;
    logic [31:0] junk;
    for (int i = 0; i < SOURCES; i++) gain_r[i] = GAIN_UNITY;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: unity gains, no gate, no mute
    add_item(0, 0, 0, 0, 4'hf);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 4'hf);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hf);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 4'h0);
    add_item(16'h8000, 0, 0, 0, 4'h1);
    add_item(0, 16'h8000, 0, 0, 4'h2);
    add_item(0, 0, 16'h8000, 0, 4'h4);
    add_item(0, 0, 0, 16'h8000, 4'h8);
    add_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 4'hf);
    add_item(16'h8000, 16'h7fff, 16'hffff, 16'h0001, 4'hf);
    wait_drained();

    // zero, tiny, above-unity and near-unity gains with a small gate
    reg_write(0, 32'd0);
    reg_write(1, 32'd1);
    reg_write(2, 32'd65535);
    reg_write(3, 32'd32767);
    reg_write(REG_MUTE, 32'd0);
    reg_write(REG_GATE_EN, 32'd1);
    reg_write(REG_GATE_THR, 32'd100);
    add_item(99, -99, 100, -100, 4'hf);
    add_item(-100, 100, -99, 99, 4'hf);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hf);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 4'hf);
    add_item(-101, 101, 16'hffff, 1, 4'hf);
    wait_drained();

    // widest threshold, some sources muted, unity gains again
    for (int i = 0; i < SOURCES; i++) reg_write(i, 32'd32768);
    reg_write(REG_MUTE, 32'd10);
    reg_write(REG_GATE_THR, 32'd2047);
    add_item(2046, -2047, -2046, 2047, 4'hf);
    add_item(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 4'hf);
    add_item(2047, 2047, -2048, 2048, 4'h5);
    wait_drained();

    // random phases, each with its own settings and idling
    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < SOURCES; i++) begin
        case ($urandom_range(0, 6))
          0: g = 0;
          1: g = 32768;
          2: g = 65535;
          3: g = 32768 + $urandom_range(1, 32767);
          4: g = $urandom_range(1, 32767);
          default: g = $urandom_range(0, 32768);
        endcase
        junk = $urandom_range(0, 1) ? ($urandom << 16) : 32'h0;
        reg_write(i, junk | 32'(g));
      end
      case (ph)
        0: reg_write(REG_MUTE, 32'd0);
        1: reg_write(REG_MUTE, 32'd15);
        default: reg_write(REG_MUTE, ($urandom_range(0, 1) ? 32'd0 : $urandom) | 32'(
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0));
      endcase
      reg_write(REG_GATE_EN, (ph % 3 == 0) ? 32'd0 :
                ((ph % 3 == 1) ? 32'd1 : $urandom));
      case ($urandom_range(0, 4))
        0: reg_write(REG_GATE_THR, 32'd0);
        1: reg_write(REG_GATE_THR, 32'd2000);
        2: reg_write(REG_GATE_THR, 32'd2047);
        3: reg_write(REG_GATE_THR, $urandom);
        default: reg_write(REG_GATE_THR, $urandom_range(0, 2000));
      endcase
      in_idle  = ph[0];
      out_idle = ph[1];
      for (int n = 0; n < 136; n++) begin
        for (int i = 0; i < SOURCES; i++) begin
          case ($urandom_range(0, 5))
            0: begin
              case ($urandom_range(0, 4))
                0: set.smp[i] = 16'h8000;
                1: set.smp[i] = 16'h7fff;
                2: set.smp[i] = 16'h0000;
                3: set.smp[i] = 16'h0001;
                default: set.smp[i] = 16'hffff;
              endcase
            end
            1, 2: set.smp[i] = 16'($urandom);
            3, 4: begin
              // just around the current threshold, either sign
              v = int'(thr_r) + $urandom_range(0, 4) - 2;
              set.smp[i] = $urandom_range(0, 1) ? 16'(-v) : 16'(v);
            end
            default: set.smp[i] = 16'($urandom_range(0, 4200) - 2100);
          endcase
        end
        set.present = 4'($urandom_range(0, 15));
        sample_sets = {sample_sets, set};
      end
      wait_drained();
    end

    // let any stray result show up
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ggm_pkg.sv
sv/ggm_regs.sv
sv/ggm_cell.sv
sv/gated_gain_mixer.sv
sim/tb.sv
